// ----- rtl/atams_pkg.sv -----
// Shared types, constants, tables and helper functions of the ATA timing mode selector.
package atams_pkg;

    typedef struct packed {
        logic        func;
        logic        unit;
        logic [15:0] pio_mode_bits;
        logic [15:0] pio_cycle_ns;
        logic [15:0] mwdma_mode_bits;
        logic [15:0] mwdma_cycle_ns;
        logic [15:0] udma_mode_bits;
        logic        use_dma;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  pio_timing_code;
        logic [7:0]  dma_timing_code;
        logic [7:0]  udma_reg_value;
        logic [15:0] pio_mode_out;
        logic [15:0] pio_cycle_out;
        logic [15:0] dma_mode_out;
        logic [15:0] dma_cycle_out;
        logic [15:0] udma_mode_out;
        logic        timing_write;
        logic [7:0]  timing_write_value;
    } out_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    localparam logic FUNC_CONFIG  = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam int NUM_UNITS = 2;

    localparam logic [15:0] PIO_SUPPORTED_MASK = 16'h001F;
    localparam logic [15:0] DMA_SUPPORTED_MASK = 16'h0007;
    localparam logic [3:0]  MODE_NONE          = 4'd8;
    localparam logic [3:0]  PIO_MAX_MODE       = 4'd4;

    localparam logic [7:0]  RST_PIO_CODE   = 8'h6d;
    localparam logic [7:0]  RST_DMA_CODE   = 8'h88;
    localparam logic [7:0]  RST_ULTRA_CODE = 8'h00;
    localparam logic [15:0] RST_PIO_MODE   = 16'h0001;
    localparam logic [15:0] RST_PIO_CYCLE  = 16'd600;
    localparam logic [15:0] RST_DMA_MODE   = 16'h0001;
    localparam logic [15:0] RST_DMA_CYCLE  = 16'd480;
    localparam logic [15:0] RST_UDMA_MODE  = 16'h0000;
    localparam logic [7:0]  RST_PROG_CODE  = 8'h6d;
    localparam logic [7:0]  NO_DMA_CODE    = 8'h00;

    localparam int PIO_TAB_LEN = 12;
    localparam int MW_TAB_LEN  = 9;

    localparam logic [7:0] PIO_TAB_CODE [PIO_TAB_LEN] = '{
        8'h00, 8'h6d, 8'h57, 8'h65, 8'h55, 8'h54, 8'h44, 8'h44, 8'h33, 8'h32, 8'h31, 8'h3F};
    localparam logic [15:0] PIO_TAB_NS [PIO_TAB_LEN] = '{
        16'd960, 16'd600, 16'd390, 16'd360, 16'd330, 16'd300,
        16'd270, 16'd240, 16'd210, 16'd180, 16'd150, 16'd120};
    localparam logic [7:0] MW_TAB_CODE [MW_TAB_LEN] = '{
        8'h00, 8'h88, 8'h65, 8'h44, 8'h43, 8'h42, 8'h32, 8'h31, 8'h3F};
    localparam logic [15:0] MW_TAB_NS [MW_TAB_LEN] = '{
        16'd960, 16'd480, 16'd360, 16'd270, 16'd240, 16'd210, 16'd180, 16'd150, 16'd120};

    // Highest set bit among bits 7..0, MODE_NONE when none is set.
    function automatic logic [3:0] mode_number(input logic [15:0] bits);
        logic [3:0] n;
        n = MODE_NONE;
        for (int i = 0; i < 8; i++) begin
            if (bits[i]) begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [15:0] min_pio_ns(input logic [3:0] mode);
        logic [15:0] ns;
        case (mode)
            4'd0:    ns = 16'd600;
            4'd1:    ns = 16'd383;
            4'd2:    ns = 16'd240;
            4'd3:    ns = 16'd180;
            default: ns = 16'd120;
        endcase
        return ns;
    endfunction

    function automatic logic [15:0] min_mw_ns(input logic [3:0] mode);
        logic [15:0] ns;
        case (mode)
            4'd1:    ns = 16'd150;
            4'd2:    ns = 16'd120;
            default: ns = 16'd480;
        endcase
        return ns;
    endfunction

    function automatic logic [7:0] ultra_code_of(input logic unit, input logic [3:0] mode);
        logic [7:0] c;
        case (mode)
            4'd0:    c = unit ? 8'hC2 : 8'h31;
            4'd1:    c = unit ? 8'h82 : 8'h21;
            default: c = unit ? 8'h42 : 8'h11;
        endcase
        return c;
    endfunction

    // Fastest code whose cycle time is not below the request; the slowest entry otherwise.
    function automatic logic [7:0] pio_search(input logic [15:0] want);
        logic [7:0] c;
        c = PIO_TAB_CODE[0];
        for (int i = 0; i < PIO_TAB_LEN; i++) begin
            if (want <= PIO_TAB_NS[i]) begin
                c = PIO_TAB_CODE[i];
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] mw_search(input logic [15:0] want);
        logic [7:0] c;
        c = MW_TAB_CODE[0];
        for (int i = 0; i < MW_TAB_LEN; i++) begin
            if (want <= MW_TAB_NS[i]) begin
                c = MW_TAB_CODE[i];
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/atams_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module atams_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output atams_pkg::cmd_t     cmd
);
    import atams_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/atams_dp.sv -----
// Datapath: per-unit timing state, mode checks, table searches and the result register.
module atams_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  atams_pkg::cmd_t     cmd,
    input  atams_pkg::in_t      item,
    output logic                done,
    output atams_pkg::out_t     result
);
    import atams_pkg::*;

    in_t         item_reg;
    out_t        result_reg;
    out_t        result_next;
    logic        done_reg;

    logic [7:0]  pio_code_reg        [NUM_UNITS];
    logic [7:0]  dma_code_reg        [NUM_UNITS];
    logic [7:0]  ultra_code_reg      [NUM_UNITS];
    logic [15:0] pio_mode_saved_reg  [NUM_UNITS];
    logic [15:0] pio_cycle_saved_reg [NUM_UNITS];
    logic [15:0] dma_mode_saved_reg  [NUM_UNITS];
    logic [15:0] dma_cycle_saved_reg [NUM_UNITS];
    logic [15:0] udma_mode_saved_reg [NUM_UNITS];
    logic [7:0]  prog_code_reg       [NUM_UNITS];

    logic        u;
    logic        cfg_ok;
    logic        cfg_upd;
    logic [3:0]  pn;
    logic [3:0]  dn;
    logic [3:0]  un;
    logic [15:0] pc_raised;
    logic [15:0] pio_min;
    logic [15:0] dc_raised;
    logic [15:0] dma_min;
    logic        dma_req;
    logic        udma_req;

    logic [7:0]  pio_code_next;
    logic [7:0]  dma_code_next;
    logic [7:0]  ultra_code_next;
    logic [15:0] pio_mode_next;
    logic [15:0] pio_cycle_next;
    logic [15:0] dma_mode_next;
    logic [15:0] dma_cycle_next;
    logic [15:0] udma_mode_next;
    logic [7:0]  prog_code_next;
    logic        wr;
    logic [7:0]  cmd_code;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign u        = item_reg.unit;
    assign dma_req  = (item_reg.mwdma_mode_bits != '0);
    assign udma_req = (item_reg.udma_mode_bits != '0);
    assign pn       = mode_number(item_reg.pio_mode_bits);
    assign dn       = mode_number(item_reg.mwdma_mode_bits);
    assign un       = mode_number(item_reg.udma_mode_bits);

    // The checks are combined with AND, so any one failure rejects the item.
    assign cfg_ok = ((item_reg.pio_mode_bits & PIO_SUPPORTED_MASK) != '0)
                 && ((item_reg.udma_mode_bits & ~DMA_SUPPORTED_MASK) == '0)
                 && ((item_reg.mwdma_mode_bits & ~DMA_SUPPORTED_MASK) == '0)
                 && !(dma_req && udma_req)
                 && (pn <= PIO_MAX_MODE);

    assign cfg_upd   = (item_reg.func == FUNC_CONFIG) && cfg_ok;
    assign pio_min   = min_pio_ns(pn);
    assign pc_raised = (item_reg.pio_cycle_ns < pio_min) ? pio_min : item_reg.pio_cycle_ns;
    assign dma_min   = min_mw_ns(dn);
    assign dc_raised = (item_reg.mwdma_cycle_ns < dma_min) ? dma_min : item_reg.mwdma_cycle_ns;

    always_comb
    begin
        pio_code_next   = pio_code_reg[u];
        dma_code_next   = dma_code_reg[u];
        ultra_code_next = ultra_code_reg[u];
        pio_mode_next   = pio_mode_saved_reg[u];
        pio_cycle_next  = pio_cycle_saved_reg[u];
        dma_mode_next   = dma_mode_saved_reg[u];
        dma_cycle_next  = dma_cycle_saved_reg[u];
        udma_mode_next  = udma_mode_saved_reg[u];
        prog_code_next  = prog_code_reg[u];
        wr              = 1'b0;
        cmd_code        = item_reg.use_dma ? dma_code_reg[u] : pio_code_reg[u];

        if (cfg_upd)
        begin
            pio_code_next   = pio_search(pc_raised);
            dma_code_next   = dma_req ? mw_search(dc_raised) : NO_DMA_CODE;
            ultra_code_next = udma_req ? ultra_code_of(u, un) : RST_ULTRA_CODE;
            pio_mode_next   = item_reg.pio_mode_bits;
            pio_cycle_next  = pc_raised;
            dma_mode_next   = item_reg.mwdma_mode_bits;
            dma_cycle_next  = dma_req ? dc_raised : '0;
            udma_mode_next  = item_reg.udma_mode_bits;
        end

        // An ultra DMA command leaves the active/recovery register alone.
        if ((item_reg.func == FUNC_COMMAND)
            && !(item_reg.use_dma && (udma_mode_saved_reg[u] != '0))
            && (cmd_code != prog_code_reg[u]))
        begin
            wr             = 1'b1;
            prog_code_next = cmd_code;
        end
    end

    always_comb
    begin
        result_next.status = ((item_reg.func == FUNC_CONFIG) && !cfg_ok)
                           ? STATUS_REJECT : STATUS_OK;
        result_next.pio_timing_code    = pio_code_next;
        result_next.dma_timing_code    = dma_code_next;
        result_next.udma_reg_value     = ultra_code_next | ultra_code_reg[~u];
        result_next.pio_mode_out       = pio_mode_next;
        result_next.pio_cycle_out      = pio_cycle_next;
        result_next.dma_mode_out       = dma_mode_next;
        result_next.dma_cycle_out      = dma_cycle_next;
        result_next.udma_mode_out      = udma_mode_next;
        result_next.timing_write       = wr;
        result_next.timing_write_value = wr ? cmd_code : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < NUM_UNITS; i++)
            begin
                pio_code_reg[i]        <= RST_PIO_CODE;
                dma_code_reg[i]        <= RST_DMA_CODE;
                ultra_code_reg[i]      <= RST_ULTRA_CODE;
                pio_mode_saved_reg[i]  <= RST_PIO_MODE;
                pio_cycle_saved_reg[i] <= RST_PIO_CYCLE;
                dma_mode_saved_reg[i]  <= RST_DMA_MODE;
                dma_cycle_saved_reg[i] <= RST_DMA_CYCLE;
                udma_mode_saved_reg[i] <= RST_UDMA_MODE;
                prog_code_reg[i]       <= RST_PROG_CODE;
            end
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                pio_code_reg[u]        <= pio_code_next;
                dma_code_reg[u]        <= dma_code_next;
                ultra_code_reg[u]      <= ultra_code_next;
                pio_mode_saved_reg[u]  <= pio_mode_next;
                pio_cycle_saved_reg[u] <= pio_cycle_next;
                dma_mode_saved_reg[u]  <= dma_mode_next;
                dma_cycle_saved_reg[u] <= dma_cycle_next;
                udma_mode_saved_reg[u] <= udma_mode_next;
                prog_code_reg[u]       <= prog_code_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/ata_timing_mode_selector.sv -----
// Top level of the ATA timing mode selector: controller, datapath and assertions.
//
// Usage: present an item on item and raise start; the item is taken at the
// rising edge where start is high and busy is low. A configure item checks
// and stores the PIO, multiword DMA and ultra DMA timing of one of two
// units; a command item picks the PIO or DMA code of the unit and flags
// whether the active/recovery register must be rewritten.
// Every item gives exactly one result on result, marked by done for one
// cycle. After the accepting edge the item passes through the controller's
// execute state, where the mode checks and the table comparators run, and
// is then captured in the result register. busy is high during the execute
// state only, so a new item cannot be taken until the execute state ends.
// The receiver cannot stall; a result is held only until the next item executes.
// Reset puts both units at PIO mode 0 and multiword DMA mode 0 timing,
// with no ultra DMA mode and the PIO code as the programmed register value.
module ata_timing_mode_selector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  atams_pkg::in_t     item,
    output logic               done,
    output atams_pkg::out_t    result
);
    import atams_pkg::*;

    cmd_t cmd;

    atams_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    atams_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // An accepted item makes the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle not followed by a result");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an executed item");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.timing_write) |-> (result.status == STATUS_OK))
        else $error("register write reported with a reject status");

    a_write_val: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.timing_write) |-> (result.timing_write_value == '0))
        else $error("write value set without a register write");

endmodule

// ----- test/ata_timing_mode_selector_test.sv -----
// Self-checking testbench for the ATA timing mode selector: directed table, then random phases.
`timescale 1ns / 1ps

module ata_timing_mode_selector_test;
    import atams_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int MAX_GAP    = 40;
    localparam int PLAN_ROWS  = 24;

    localparam logic [15:0] PIO_STEP_NS [12] = '{
        16'd960, 16'd600, 16'd390, 16'd360, 16'd330, 16'd300,
        16'd270, 16'd240, 16'd210, 16'd180, 16'd150, 16'd120};
    localparam logic [7:0] PIO_STEP_CODE [12] = '{
        8'h00, 8'h6d, 8'h57, 8'h65, 8'h55, 8'h54, 8'h44, 8'h44, 8'h33, 8'h32, 8'h31, 8'h3F};
    localparam logic [15:0] DMA_STEP_NS [9] = '{
        16'd960, 16'd480, 16'd360, 16'd270, 16'd240, 16'd210, 16'd180, 16'd150, 16'd120};
    localparam logic [7:0] DMA_STEP_CODE [9] = '{
        8'h00, 8'h88, 8'h65, 8'h44, 8'h43, 8'h42, 8'h32, 8'h31, 8'h3F};
    localparam int PIO_FLOOR_NS [5] = '{600, 383, 240, 180, 120};
    localparam int DMA_FLOOR_NS [3] = '{480, 150, 120};
    localparam logic [7:0] ULTRA_UNIT_CODE [2][3] = '{
        '{8'h31, 8'h21, 8'h11}, '{8'hC2, 8'h82, 8'h42}};

    typedef struct {
        in_t  stim;
        logic typed;
        out_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  item;
    logic done;
    out_t result;

    // Per-unit copy of the timing state.
    logic [7:0]  unit_pio_code [2];
    logic [7:0]  unit_dma_code [2];
    logic [7:0]  unit_ultra_code [2];
    logic [15:0] unit_pio_mode [2];
    logic [15:0] unit_pio_cycle [2];
    logic [15:0] unit_dma_mode [2];
    logic [15:0] unit_dma_cycle [2];
    logic [15:0] unit_udma_mode [2];
    logic [7:0]  unit_programmed [2];

    out_t      pending_results [$];
    plan_row_t plan [PLAN_ROWS];
    int        mismatches;
    int        idle_cycles;

    ata_timing_mode_selector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 50)
        begin
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int highest_mode(input logic [15:0] bits);
        for (int n = 7; n >= 0; n--)
        begin
            if (bits[n])
            begin
                return n;
            end
        end
        return 8;
    endfunction

    function automatic logic [7:0] pio_code_for(input int want);
        for (int i = 11; i >= 0; i--)
        begin
            if (want <= PIO_STEP_NS[i])
            begin
                return PIO_STEP_CODE[i];
            end
        end
        return PIO_STEP_CODE[0];
    endfunction

    function automatic logic [7:0] dma_code_for(input int want);
        for (int i = 8; i >= 0; i--)
        begin
            if (want <= DMA_STEP_NS[i])
            begin
                return DMA_STEP_CODE[i];
            end
        end
        return DMA_STEP_CODE[0];
    endfunction

    function automatic void reset_units();
        for (int u = 0; u < 2; u++)
        begin
            unit_pio_code[u]   = 8'h6d;
            unit_dma_code[u]   = 8'h88;
            unit_ultra_code[u] = 8'h00;
            unit_pio_mode[u]   = 16'h0001;
            unit_pio_cycle[u]  = 16'd600;
            unit_dma_mode[u]   = 16'h0001;
            unit_dma_cycle[u]  = 16'd480;
            unit_udma_mode[u]  = 16'h0000;
            unit_programmed[u] = 8'h6d;
        end
    endfunction

    // Applies one item to the unit state and returns the result it should give.
    function automatic out_t select_timing(input in_t it);
        out_t       res;
        int         u;
        int         pn;
        int         dn;
        int         un;
        int         pc;
        int         dc;
        logic       ok;
        logic [7:0] dcode;
        logic [7:0] ucode;
        logic [7:0] v;
        res = '0;
        u = it.unit;
        res.status = STATUS_OK;
        if (it.func == FUNC_CONFIG)
        begin
            ok = 1'b1;
            if ((it.pio_mode_bits & PIO_SUPPORTED_MASK) == 16'h0000)
            begin
                ok = 1'b0;
            end
            if ((it.udma_mode_bits & ~DMA_SUPPORTED_MASK) != 16'h0000)
            begin
                ok = 1'b0;
            end
            if ((it.mwdma_mode_bits & ~DMA_SUPPORTED_MASK) != 16'h0000)
            begin
                ok = 1'b0;
            end
            if (it.mwdma_mode_bits != 16'h0000 && it.udma_mode_bits != 16'h0000)
            begin
                ok = 1'b0;
            end
            pn = highest_mode(it.pio_mode_bits);
            if (pn > 4)
            begin
                ok = 1'b0;
            end
            if (ok)
            begin
                pc = it.pio_cycle_ns;
                if (pc < PIO_FLOOR_NS[pn])
                begin
                    pc = PIO_FLOOR_NS[pn];
                end
                dcode = 8'h00;
                dc = 0;
                if (it.mwdma_mode_bits != 16'h0000)
                begin
                    dn = highest_mode(it.mwdma_mode_bits);
                    if (dn > 2)
                    begin
                        dn = 0;
                    end
                    dc = it.mwdma_cycle_ns;
                    if (dc < DMA_FLOOR_NS[dn])
                    begin
                        dc = DMA_FLOOR_NS[dn];
                    end
                    dcode = dma_code_for(dc);
                end
                ucode = 8'h00;
                if (it.udma_mode_bits != 16'h0000)
                begin
                    un = highest_mode(it.udma_mode_bits);
                    if (un > 2)
                    begin
                        un = 2;
                    end
                    ucode = ULTRA_UNIT_CODE[u][un];
                end
                unit_pio_code[u]   = pio_code_for(pc);
                unit_dma_code[u]   = dcode;
                unit_ultra_code[u] = ucode;
                unit_pio_mode[u]   = it.pio_mode_bits;
                unit_pio_cycle[u]  = 16'(pc);
                unit_dma_mode[u]   = it.mwdma_mode_bits;
                unit_dma_cycle[u]  = 16'(dc);
                unit_udma_mode[u]  = it.udma_mode_bits;
            end
            else
            begin
                res.status = STATUS_REJECT;
            end
        end
        else if (!(it.use_dma && unit_udma_mode[u] != 16'h0000))
        begin
            v = it.use_dma ? unit_dma_code[u] : unit_pio_code[u];
            if (v != unit_programmed[u])
            begin
                unit_programmed[u]     = v;
                res.timing_write       = 1'b1;
                res.timing_write_value = v;
            end
        end
        res.pio_timing_code = unit_pio_code[u];
        res.dma_timing_code = unit_dma_code[u];
        res.udma_reg_value  = unit_ultra_code[0] | unit_ultra_code[1];
        res.pio_mode_out    = unit_pio_mode[u];
        res.pio_cycle_out   = unit_pio_cycle[u];
        res.dma_mode_out    = unit_dma_mode[u];
        res.dma_cycle_out   = unit_dma_cycle[u];
        res.udma_mode_out   = unit_udma_mode[u];
        return res;
    endfunction

    function automatic in_t cfg(input logic unit, input logic [15:0] pm, input logic [15:0] pc,
                                input logic [15:0] dm, input logic [15:0] dc,
                                input logic [15:0] um);
        in_t it;
        it = '0;
        it.func            = FUNC_CONFIG;
        it.unit            = unit;
        it.pio_mode_bits   = pm;
        it.pio_cycle_ns    = pc;
        it.mwdma_mode_bits = dm;
        it.mwdma_cycle_ns  = dc;
        it.udma_mode_bits  = um;
        return it;
    endfunction

    function automatic in_t cmd(input logic unit, input logic dma);
        in_t it;
        it = '0;
        it.func    = FUNC_COMMAND;
        it.unit    = unit;
        it.use_dma = dma;
        return it;
    endfunction

    function automatic out_t res_of(input logic st, input logic [7:0] pcode,
                                    input logic [7:0] dcode, input logic [7:0] ureg,
                                    input logic [15:0] pmode, input logic [15:0] pcyc,
                                    input logic [15:0] dmode, input logic [15:0] dcyc,
                                    input logic [15:0] umode, input logic tw,
                                    input logic [7:0] twv);
        out_t r;
        r.status             = st;
        r.pio_timing_code    = pcode;
        r.dma_timing_code    = dcode;
        r.udma_reg_value     = ureg;
        r.pio_mode_out       = pmode;
        r.pio_cycle_out      = pcyc;
        r.dma_mode_out       = dmode;
        r.dma_cycle_out      = dcyc;
        r.udma_mode_out      = umode;
        r.timing_write       = tw;
        r.timing_write_value = twv;
        return r;
    endfunction

    // Random item: commands, well-formed configure requests and raw noise.
    function automatic in_t random_item();
        in_t         it;
        logic [95:0] raw;
        int          kind;
        int          dma_class;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_t)-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            it.func = FUNC_COMMAND;
        end
        else if (kind < 85)
        begin
            it.func = FUNC_CONFIG;
            it.pio_mode_bits = {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, 3'b000,
                                5'($urandom_range(1, 31))};
            it.pio_cycle_ns = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 1000));
            it.mwdma_cycle_ns = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 1000));
            dma_class = $urandom_range(0, 2);
            it.mwdma_mode_bits = (dma_class == 1) ? 16'($urandom_range(1, 7)) : 16'h0000;
            it.udma_mode_bits  = (dma_class == 2) ? 16'($urandom_range(1, 7)) : 16'h0000;
        end
        else
        begin
            it.func = FUNC_CONFIG;
        end
        return it;
    endfunction

    function automatic int idle_gap(input int percent);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(0, 99) < percent)
        begin
            g++;
        end
        return g;
    endfunction

    // Holds start until the item is taken; start stays high when no gap follows.
    task automatic send_item(input in_t it, input logic typed, input out_t want, input int gap);
        out_t model;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        model = select_timing(it);
        pending_results.push_back(typed ? want : model);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int count, input int percent);
        out_t none;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            send_item(random_item(), 1'b0, none, idle_gap(percent));
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(result), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    report_mismatch("status", result.status, want.status);
                end
                if (result.pio_timing_code !== want.pio_timing_code)
                begin
                    report_mismatch("pio_timing_code", result.pio_timing_code,
                                    want.pio_timing_code);
                end
                if (result.dma_timing_code !== want.dma_timing_code)
                begin
                    report_mismatch("dma_timing_code", result.dma_timing_code,
                                    want.dma_timing_code);
                end
                if (result.udma_reg_value !== want.udma_reg_value)
                begin
                    report_mismatch("udma_reg_value", result.udma_reg_value,
                                    want.udma_reg_value);
                end
                if (result.pio_mode_out !== want.pio_mode_out)
                begin
                    report_mismatch("pio_mode_out", result.pio_mode_out, want.pio_mode_out);
                end
                if (result.pio_cycle_out !== want.pio_cycle_out)
                begin
                    report_mismatch("pio_cycle_out", result.pio_cycle_out, want.pio_cycle_out);
                end
                if (result.dma_mode_out !== want.dma_mode_out)
                begin
                    report_mismatch("dma_mode_out", result.dma_mode_out, want.dma_mode_out);
                end
                if (result.dma_cycle_out !== want.dma_cycle_out)
                begin
                    report_mismatch("dma_cycle_out", result.dma_cycle_out, want.dma_cycle_out);
                end
                if (result.udma_mode_out !== want.udma_mode_out)
                begin
                    report_mismatch("udma_mode_out", result.udma_mode_out, want.udma_mode_out);
                end
                if (result.timing_write !== want.timing_write)
                begin
                    report_mismatch("timing_write", result.timing_write, want.timing_write);
                end
                if (result.timing_write_value !== want.timing_write_value)
                begin
                    report_mismatch("timing_write_value", result.timing_write_value,
                                    want.timing_write_value);
                end
            end
        end
    end

    // Ends the run when neither side makes progress for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        mismatches  = 0;
        idle_cycles = 0;
        reset_units();

        // Results that can be read straight off the reset state are typed in.
        plan[0]  = '{cmd(1'b0, 1'b0), 1'b1, res_of(STATUS_OK, 8'h6d, 8'h88, 8'h00,
                     16'h0001, 16'd600, 16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        plan[1]  = '{cmd(1'b1, 1'b1), 1'b1, res_of(STATUS_OK, 8'h6d, 8'h88, 8'h00,
                     16'h0001, 16'd600, 16'h0001, 16'd480, 16'h0000, 1'b1, 8'h88)};
        plan[2]  = '{cfg(1'b0, 16'h0000, 16'd0, 16'h0000, 16'd0, 16'h0000), 1'b1,
                     res_of(STATUS_REJECT, 8'h6d, 8'h88, 8'h00, 16'h0001, 16'd600,
                     16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        plan[3]  = '{cfg(1'b0, 16'h0020, 16'hFFFF, 16'h0000, 16'd0, 16'h0000), 1'b1,
                     res_of(STATUS_REJECT, 8'h6d, 8'h88, 8'h00, 16'h0001, 16'd600,
                     16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        plan[4]  = '{cfg(1'b1, 16'h0001, 16'd0, 16'h0000, 16'd0, 16'h0008), 1'b1,
                     res_of(STATUS_REJECT, 8'h6d, 8'h88, 8'h00, 16'h0001, 16'd600,
                     16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        plan[5]  = '{cfg(1'b0, 16'h0001, 16'd0, 16'h0010, 16'd0, 16'h0000), 1'b1,
                     res_of(STATUS_REJECT, 8'h6d, 8'h88, 8'h00, 16'h0001, 16'd600,
                     16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        plan[6]  = '{cfg(1'b1, 16'h0001, 16'd0, 16'h0001, 16'd0, 16'h0001), 1'b1,
                     res_of(STATUS_REJECT, 8'h6d, 8'h88, 8'h00, 16'h0001, 16'd600,
                     16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        plan[7]  = '{cfg(1'b0, 16'h0021, 16'd0, 16'h0000, 16'd0, 16'h0000), 1'b1,
                     res_of(STATUS_REJECT, 8'h6d, 8'h88, 8'h00, 16'h0001, 16'd600,
                     16'h0001, 16'd480, 16'h0000, 1'b0, 8'h00)};
        // Upper mode bits take no part in the mode number.
        plan[8]  = '{cfg(1'b0, 16'hFF01, 16'd0, 16'h0000, 16'd0, 16'h0000), 1'b0, '0};
        plan[9]  = '{cfg(1'b0, 16'h001F, 16'd0, 16'h0004, 16'd0, 16'h0000), 1'b0, '0};
        plan[10] = '{cfg(1'b1, 16'h0010, 16'hFFFF, 16'h0000, 16'd0, 16'h0007), 1'b0, '0};
        plan[11] = '{cfg(1'b0, 16'h0008, 16'd200, 16'h0000, 16'hFFFF, 16'h0001), 1'b0, '0};
        plan[12] = '{cmd(1'b0, 1'b1), 1'b0, '0};
        plan[13] = '{cmd(1'b0, 1'b0), 1'b0, '0};
        plan[14] = '{cmd(1'b1, 1'b1), 1'b0, '0};
        plan[15] = '{cmd(1'b1, 1'b0), 1'b0, '0};
        plan[16] = '{cfg(1'b1, 16'h0002, 16'd383, 16'h0002, 16'd150, 16'h0000), 1'b0, '0};
        plan[17] = '{cmd(1'b1, 1'b1), 1'b0, '0};
        plan[18] = '{cmd(1'b1, 1'b1), 1'b0, '0};
        plan[19] = '{cfg(1'b0, 16'h0004, 16'd961, 16'h0001, 16'hFFFF, 16'h0000), 1'b0, '0};
        plan[20] = '{cfg(1'b1, 16'h0001, 16'd0, 16'h0000, 16'd0, 16'h0002), 1'b0, '0};
        plan[21] = '{cfg(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0};
        plan[21].stim.use_dma = 1'b1;
        plan[22] = '{'1, 1'b0, '0};
        plan[23] = '{cfg(1'b0, 16'h001F, 16'd120, 16'h0000, 16'd0, 16'h0000), 1'b0, '0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            send_item(plan[r].stim, plan[r].typed, plan[r].want, 0);
        end
        drain_results();

        run_phase(300, 0);
        run_phase(300, 80);
        run_phase(300, 12);
        run_phase(350, 0);

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- ata_timing_mode_selector.f -----
rtl/atams_pkg.sv
rtl/atams_ctrl.sv
rtl/atams_dp.sv
rtl/ata_timing_mode_selector.sv
test/ata_timing_mode_selector_test.sv
